[rtl/square_free_test_macros.svh]
// Assertion macros used by the square-free test checker
`ifndef SQUARE_FREE_TEST_MACROS_SVH
`define SQUARE_FREE_TEST_MACROS_SVH

// same-cycle implication
`define SQF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SQF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/sqf_pkg.sv]
// Package: widths, defaults, control and status structs of the square-free test
package sqf_pkg;

  localparam int VALUE_WIDTH_DEF = 14;

  typedef struct packed {
    logic init;
    logic advance;
  } sqf_base_ctl_t;

  typedef struct packed {
    logic done;
    logic zero;
  } sqf_rem_stat_t;

endpackage

[rtl/sqf_base.sv]
// Trial base and its square, stepped by (b+1)^2 = b^2 + 2b + 1
module sqf_base import sqf_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  sqf_base_ctl_t          ctl,
  output logic [VALUE_WIDTH:0]   sq
);

  localparam int BW = VALUE_WIDTH / 2 + 1;

  logic [BW-1:0]        b_r, b_nxt;
  logic [VALUE_WIDTH:0] sq_r, sq_nxt;

  always_comb begin
    b_nxt  = b_r;
    sq_nxt = sq_r;
    priority if (ctl.init) begin
      b_nxt  = BW'(2);
      sq_nxt = (VALUE_WIDTH + 1)'(4);
    end else if (ctl.advance) begin
      b_nxt  = b_r + BW'(1);
      sq_nxt = sq_r + (VALUE_WIDTH + 1)'({b_r, 1'b1});
    end else begin
      b_nxt  = b_r;
      sq_nxt = sq_r;
    end
  end

  always_ff @(posedge clk) begin
    b_r  <= b_nxt;
    sq_r <= sq_nxt;
  end

  assign sq = sq_r;

endmodule

[rtl/sqf_rem.sv]
// Bit-serial restoring remainder unit, one dividend bit per cycle
module sqf_rem import sqf_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [VALUE_WIDTH-1:0] dividend,
  input  logic [VALUE_WIDTH-1:0] divisor,
  output sqf_rem_stat_t          stat
);

  localparam int CW = $clog2(VALUE_WIDTH + 1);

  logic [VALUE_WIDTH-1:0] sh_r, sh_nxt;
  logic [VALUE_WIDTH-1:0] rem_r, rem_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic                   done_r, done_nxt;
  logic [VALUE_WIDTH:0]   trial;

  always_comb begin
    trial    = {rem_r, sh_r[VALUE_WIDTH-1]};
    sh_nxt   = sh_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    priority if (start) begin
      sh_nxt  = dividend;
      rem_nxt = '0;
      cnt_nxt = CW'(VALUE_WIDTH);
    end else if (cnt_r != '0) begin
      sh_nxt  = sh_r << 1;
      cnt_nxt = cnt_r - CW'(1);
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = VALUE_WIDTH'(trial - {1'b0, divisor});
      end else begin
        rem_nxt = trial[VALUE_WIDTH-1:0];
      end
      done_nxt = (cnt_r == CW'(1));
    end else begin
      done_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    sh_r  <= sh_nxt;
    rem_r <= rem_nxt;
  end

  assign stat.done = done_r;
  assign stat.zero = (rem_r == '0);

endmodule

[rtl/square_free_test.sv]
// Top level: square-free test by trial division over square divisors
//
//  channel  direction  handshake          beat
//  in_      input      start / busy       in_value
//  out_     output     out_valid strobe   out_value_out, out_square_free
//
// Each trial base tests b*b against the value and starts the remainder unit,
// waits for the bit-serial remainder unit, then acts on its result. An item
// takes at most (floor(sqrt(n)) - 1) bases and stops at a square divisor.
// The result strobe rises in the cycle busy falls; the receiver cannot stall.
// Reset is synchronous, active low, and returns the block to idle.
module square_free_test import sqf_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [VALUE_WIDTH-1:0] in_value,
  output logic                   out_valid,
  output logic [VALUE_WIDTH-1:0] out_value_out,
  output logic                   out_square_free
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_CHECK = 3'b010,
    ST_DIV   = 3'b100
  } state_t;

  state_t                 state_r, state_nxt;
  logic [VALUE_WIDTH-1:0] n_r, n_nxt;
  logic                   valid_r, valid_nxt;
  logic                   free_r, free_nxt;
  logic [VALUE_WIDTH:0]   sq;
  logic                   rem_start;
  sqf_base_ctl_t          base_ctl;
  sqf_rem_stat_t          rem_stat;

  sqf_base #(.VALUE_WIDTH(VALUE_WIDTH)) u_base (
    .clk (clk),
    .ctl (base_ctl),
    .sq  (sq)
  );

  sqf_rem #(.VALUE_WIDTH(VALUE_WIDTH)) u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rem_start),
    .dividend (n_r),
    .divisor  (sq[VALUE_WIDTH-1:0]),
    .stat     (rem_stat)
  );

  always_comb begin
    state_nxt        = state_r;
    n_nxt            = n_r;
    valid_nxt        = 1'b0;
    free_nxt         = free_r;
    rem_start        = 1'b0;
    base_ctl.init    = 1'b0;
    base_ctl.advance = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          n_nxt         = in_value;
          base_ctl.init = 1'b1;
          state_nxt     = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sq > {1'b0, n_r}) begin
          free_nxt  = 1'b1;
          valid_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          rem_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (rem_stat.done) begin
          if (rem_stat.zero) begin
            free_nxt  = 1'b0;
            valid_nxt = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            base_ctl.advance = 1'b1;
            state_nxt        = ST_CHECK;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
    n_r    <= n_nxt;
    free_r <= free_nxt;
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = valid_r;
  assign out_value_out   = n_r;
  assign out_square_free = free_r;

endmodule

[rtl/sqf_checker.sv]
// Port-level checker for the square-free test, bound to the top level
`include "square_free_test_macros.svh"

module sqf_checker import sqf_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   start,
  input logic                   busy,
  input logic                   out_valid,
  input logic [VALUE_WIDTH-1:0] out_value_out,
  input logic                   out_square_free
);

  `SQF_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted beat did not raise busy")
  `SQF_ASSERT_NOW(a_strobe_idle, out_valid, !busy, "result strobe while busy")
  `SQF_ASSERT_NEXT(a_strobe_once, out_valid, !out_valid, "result strobe held past one cycle")
  `SQF_ASSERT_NOW(a_strobe_after_work, out_valid, $past(busy), "result without work")
  `SQF_ASSERT_NOW(a_small_free, out_valid && (out_value_out < VALUE_WIDTH'(4)), out_square_free, "value below four reported not square-free")

endmodule

bind square_free_test sqf_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_sqf_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_value_out   (out_value_out),
  .out_square_free (out_square_free)
);

[sim/tb_top.sv]
// Testbench for square_free_test: directed and random numbers, verdicts typed in or by trial division
`timescale 1ns / 100ps

module tb_top;
  import sqf_pkg::*;

  localparam int W            = VALUE_WIDTH_DEF;
  localparam int VMAX         = (1 << W) - 1;
  localparam int N_RANDOM     = 310;
  localparam int DRAIN_CYCLES = 128 * (W + 2) + 16;
  localparam int CYCLE_LIMIT  = (N_RANDOM + 40) * (DRAIN_CYCLES + 8) * 3;
  localparam int N_PROBES     = 20;

  typedef struct packed {
    logic [W-1:0] value;
    logic         square_free;
  } verdict_t;

  typedef struct packed {
    logic [W-1:0] value;
    logic         known;
    logic         square_free;
  } probe_t;

  // value, expectation typed in, square_free
  localparam probe_t PROBE_TBL [N_PROBES] = '{
    '{0,     1'b1, 1'b1},
    '{1,     1'b1, 1'b1},
    '{2,     1'b1, 1'b1},
    '{3,     1'b1, 1'b1},
    '{4,     1'b1, 1'b0},
    '{8,     1'b1, 1'b0},
    '{9,     1'b1, 1'b0},
    '{6,     1'b0, 1'b0},
    '{12,    1'b0, 1'b0},
    '{49,    1'b1, 1'b0},
    '{8192,  1'b1, 1'b0},
    '{16129, 1'b1, 1'b0},
    '{16128, 1'b0, 1'b0},
    '{16381, 1'b0, 1'b0},
    '{16383, 1'b0, 1'b0},
    '{10922, 1'b0, 1'b0},
    '{5461,  1'b0, 1'b0},
    '{16382, 1'b0, 1'b0},
    '{15876, 1'b1, 1'b0},
    '{15877, 1'b0, 1'b0}
  };

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         start = 1'b0;
  logic [W-1:0] in_value = '0;
  logic         busy;
  logic         out_valid;
  logic [W-1:0] out_value_out;
  logic         out_square_free;

  verdict_t verdict_q [$];
  verdict_t head;
  int       errors = 0;
  int       results = 0;
  int       not_free = 0;
  int       sent = 0;
  int       cycles = 0;

  square_free_test #(.VALUE_WIDTH(W)) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_value_out  (out_value_out),
    .out_square_free(out_square_free)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic is_square_free(input logic [W-1:0] n);
    int b;
    for (b = 2; b * b <= int'(n); b++) begin
      if (int'(n) % (b * b) == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [W-1:0] pick_value();
    int b;
    int k;
    int v;
    case ($urandom_range(9))
      5, 6: v = $urandom_range(255);
      7, 8: begin
        b = $urandom_range(127, 2);
        k = $urandom_range(VMAX / (b * b), 1);
        v = b * b * k;
      end
      9: v = $urandom_range(VMAX, VMAX - 511);
      default: v = $urandom_range(VMAX);
    endcase
    return v[W-1:0];
  endfunction

  // drive one beat, hold until accepted, then log its verdict
  task automatic send_value(input logic [W-1:0] v, input logic known, input logic sf,
                            input bit no_idle);
    int gap;
    gap = 0;
    if (!no_idle && $urandom_range(99) < 27) gap = $urandom_range(6, 1);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (busy);
    verdict_q.push_back('{value: v, square_free: known ? sf : is_square_free(v)});
    sent++;
  endtask

  initial begin
    int i;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (i = 0; i < N_PROBES; i++) begin
      send_value(PROBE_TBL[i].value, PROBE_TBL[i].known, PROBE_TBL[i].square_free, 1'b0);
    end
    for (i = 0; i < N_RANDOM; i++) begin
      send_value(pick_value(), 1'b0, 1'b0, i >= 120 && i < 180);
    end
    start <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d numbers tested (%0d directed, %0d random), %0d results checked",
             sent, N_PROBES, N_RANDOM, results);
    $display("%0d reported not square-free, %0d mismatches", not_free, errors);
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected result value_out=%0d square_free=%0b", $time,
                 out_value_out, out_square_free);
        errors++;
      end else begin
        head = verdict_q.pop_front();
        results++;
        if (!out_square_free) not_free++;
        if (out_value_out !== head.value) begin
          $display("%0t: value_out expected %0d actual %0d", $time, head.value,
                   out_value_out);
          errors++;
        end
        if (out_square_free !== head.square_free) begin
          $display("%0t: square_free for %0d expected %0b actual %0b", $time, head.value,
                   head.square_free, out_square_free);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results pending", $time, cycles,
               verdict_q.size());
      $display("tb_top NOT OK");
      $finish;
    end
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/sqf_pkg.sv
rtl/sqf_base.sv
rtl/sqf_rem.sv
rtl/square_free_test.sv
rtl/sqf_checker.sv
sim/tb_top.sv
